/* rtl/core/adrc_pkg.sv */
// ----------------------------------------------------------------------------
// adrc_pkg
// Shared types, register indexes and constants of the dynamic range compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package adrc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOPE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAKEUP    = 3'd4;

   localparam logic [15:0] RST_THRESHOLD = 16'hEC00;
   localparam logic [15:0] RST_SLOPE     = 16'd49152;
   localparam logic [15:0] RST_ATTACK    = 16'd66;
   localparam logic [15:0] RST_RELEASE   = 16'd7;
   localparam logic [15:0] RST_MAKEUP    = 16'd4096;

   // 20*log10(2) and its reciprocal, Q16
   localparam logic [31:0] DB_PER_OCTAVE = 32'd394566;
   localparam logic [31:0] OCTAVE_PER_DB = 32'd10885;
   localparam logic [30:0] ONE_Q30       = 31'h4000_0000;

   typedef struct packed {
      logic signed [15:0] threshold_level;
      logic [15:0]        slope_factor;
      logic [15:0]        attack_weight;
      logic [15:0]        release_weight;
      logic [15:0]        makeup_gain;
   } adrc_cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_NORM, ST_LOG_MUL, ST_LOG_UPD, ST_DB_MUL, ST_DB_UPD,
      ST_TGT_MUL, ST_TGT_UPD, ST_SM_MUL, ST_SM_UPD, ST_OCT_MUL, ST_OCT_UPD,
      ST_POW_MUL, ST_POW_UPD, ST_MK_MUL, ST_MK_UPD, ST_OUT_MUL, ST_OUT_UPD,
      ST_DONE
   } adrc_state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_NORM, OP_LOG_MUL, OP_LOG_UPD, OP_DB_MUL, OP_DB_UPD,
      OP_TGT_MUL, OP_TGT_UPD, OP_SM_MUL, OP_SM_UPD, OP_OCT_MUL, OP_OCT_UPD,
      OP_POW_MUL, OP_POW_UPD, OP_MK_MUL, OP_MK_UPD, OP_OUT_MUL, OP_OUT_UPD
   } adrc_op_type;

   typedef struct packed {
      adrc_op_type op;
      logic        load_out;
   } adrc_cmd_type;

   typedef struct packed {
      logic mag_zero;
      logic norm_done;
   } adrc_sts_type;

   // floor(sqrt(v)), bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bv;
      v   = v_in;
      res = '0;
      bv  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bv) begin
            v   = v - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // 2^(2^-j) in Q1.30 by repeated square roots, elaboration only
   function automatic logic [30:0] frac_root(input int j);
      logic [63:0] v;
      logic [63:0] r;
      v = 64'd2 << 60;
      r = '0;
      for (int k = 0; k < j; k++) begin
         r = isqrt64(v);
         v = r << 30;
      end
      return r[30:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/adrc_ctrl.sv */
// ----------------------------------------------------------------------------
// adrc_ctrl
// Sequencer: steps the datapath through level, target, smoothing and gain.
// ----------------------------------------------------------------------------
`default_nettype none

module adrc_ctrl import adrc_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 10,
   parameter int IW              = $clog2(TABLE_ADDR_BITS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire adrc_sts_type  sts,
   input  wire logic          out_free,
   output adrc_cmd_type       cmd,
   output logic [IW-1:0]      iter
);

   localparam logic [IW-1:0] ITER_LAST = IW'(TABLE_ADDR_BITS - 1);

   adrc_state_type state_ff, state_in;
   logic [IW-1:0]  iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_NORM;
         ST_NORM: begin
            if (sts.mag_zero)       state_in = ST_TGT_MUL;
            else if (sts.norm_done) state_in = ST_LOG_MUL;
         end
         ST_LOG_MUL: state_in = ST_LOG_UPD;
         ST_LOG_UPD: begin
            if (iter_ff == ITER_LAST) begin
               state_in = ST_DB_MUL;
               iter_in  = '0;
            end else begin
               state_in = ST_LOG_MUL;
               iter_in  = iter_ff + 1'b1;
            end
         end
         ST_DB_MUL:  state_in = ST_DB_UPD;
         ST_DB_UPD:  state_in = ST_TGT_MUL;
         ST_TGT_MUL: state_in = ST_TGT_UPD;
         ST_TGT_UPD: state_in = ST_SM_MUL;
         ST_SM_MUL:  state_in = ST_SM_UPD;
         ST_SM_UPD:  state_in = ST_OCT_MUL;
         ST_OCT_MUL: state_in = ST_OCT_UPD;
         ST_OCT_UPD: state_in = ST_POW_MUL;
         ST_POW_MUL: state_in = ST_POW_UPD;
         ST_POW_UPD: begin
            if (iter_ff == ITER_LAST) begin
               state_in = ST_MK_MUL;
               iter_in  = '0;
            end else begin
               state_in = ST_POW_MUL;
               iter_in  = iter_ff + 1'b1;
            end
         end
         ST_MK_MUL:  state_in = ST_MK_UPD;
         ST_MK_UPD:  state_in = ST_OUT_MUL;
         ST_OUT_MUL: state_in = ST_OUT_UPD;
         ST_OUT_UPD: state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = OP_NOP;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_NORM:    cmd.op = OP_NORM;
         ST_LOG_MUL: cmd.op = OP_LOG_MUL;
         ST_LOG_UPD: cmd.op = OP_LOG_UPD;
         ST_DB_MUL:  cmd.op = OP_DB_MUL;
         ST_DB_UPD:  cmd.op = OP_DB_UPD;
         ST_TGT_MUL: cmd.op = OP_TGT_MUL;
         ST_TGT_UPD: cmd.op = OP_TGT_UPD;
         ST_SM_MUL:  cmd.op = OP_SM_MUL;
         ST_SM_UPD:  cmd.op = OP_SM_UPD;
         ST_OCT_MUL: cmd.op = OP_OCT_MUL;
         ST_OCT_UPD: cmd.op = OP_OCT_UPD;
         ST_POW_MUL: cmd.op = OP_POW_MUL;
         ST_POW_UPD: cmd.op = OP_POW_UPD;
         ST_MK_MUL:  cmd.op = OP_MK_MUL;
         ST_MK_UPD:  cmd.op = OP_MK_UPD;
         ST_OUT_MUL: cmd.op = OP_OUT_MUL;
         ST_OUT_UPD: cmd.op = OP_OUT_UPD;
         ST_DONE:    cmd.load_out = out_free;
         default:    cmd.op = OP_NOP;
      endcase
   end

   assign iter = iter_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_NORM))
      else $error("accepted beat did not start normalization");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result register overwritten while full");

   a_log_loop_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG_UPD && iter_ff == ITER_LAST)
      |=> (state_ff == ST_DB_MUL && iter_ff == '0))
      else $error("log loop did not close cleanly");

endmodule

`default_nettype wire

/* rtl/core/adrc_dp.sv */
// ----------------------------------------------------------------------------
// adrc_dp
// Datapath: one shared 32x32 multiplier with registered product, plus the
// level, reduction and gain registers.
// ----------------------------------------------------------------------------
`default_nettype none

module adrc_dp import adrc_pkg::*; #(
   parameter int SAMPLE_BITS     = 16,
   parameter int TABLE_ADDR_BITS = 10,
   parameter int IW              = $clog2(TABLE_ADDR_BITS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire adrc_cmd_type           cmd,
   input  wire logic [IW-1:0]          iter,
   input  wire adrc_cfg_type           cfg,
   input  wire logic [SAMPLE_BITS-1:0] req_sample_in,
   output adrc_sts_type                sts,
   output logic [SAMPLE_BITS-1:0]      y
);

   localparam int SB = SAMPLE_BITS;
   localparam int T  = TABLE_ADDR_BITS;

   logic [30:0] roots [T];
   for (genvar k = 0; k < T; k++) begin : g_root
      localparam logic [30:0] R = frac_root(k + 1);
      assign roots[k] = R;
   end

   logic               x_neg_ff;
   logic [SB-1:0]      mag_ff;
   logic [30:0]        m_ff;
   logic [4:0]         s_ff;
   logic [T-1:0]       frac_ff;
   logic signed [16:0] lvl_ff;
   logic signed [24:0] tgt_ff;
   logic signed [23:0] red_ff;
   logic [7:0]         ip_ff;
   logic [T-1:0]       pw_ff;
   logic [30:0]        g_ff;
   logic [30:0]        gq_ff;
   logic [SB-1:0]      y_ff;
   logic [63:0]        prod_ff;

   logic [31:0]        mul_a, mul_b;
   logic [SB-1:0]      in_mag;
   logic [31:0]        sq;
   logic [T+5:0]       lneg;
   logic [23:0]        db_w;
   logic signed [16:0] thr;
   logic               over_gt;
   logic [16:0]        over;
   logic signed [24:0] diff;
   logic               diff_neg;
   logic [24:0]        absd;
   logic [23:0]        stepm;
   logic [23:0]        redmag;
   logic [63:0]        n_w;
   logic [T-1:0]       fr;
   logic [7:0]         ip_n;
   logic [30:0]        gsh;
   logic [63:0]        rnd;
   logic [37:0]        pr;
   logic               big;

   always_comb begin
      in_mag  = req_sample_in[SB-1] ? (~req_sample_in + 1'b1) : req_sample_in;
      sq      = prod_ff[61:30];
      lneg    = {1'b0, s_ff - 5'(31 - SB), T'(0)} - {6'b0, frac_ff};
      db_w    = prod_ff[T+8 +: 24];
      thr     = {cfg.threshold_level[15], cfg.threshold_level};
      over_gt = lvl_ff > thr;
      over    = 17'(lvl_ff - thr);
      diff    = tgt_ff - {red_ff[23], red_ff};
      diff_neg = diff[24];
      absd    = diff_neg ? 25'(-diff) : 25'(diff);
      stepm   = prod_ff[16 +: 24];
      redmag  = 24'(-red_ff);
      n_w     = prod_ff >> (31 - T);
      fr      = n_w[T-1:0];
      ip_n    = n_w[T +: 8];
      gsh     = (ip_ff >= 8'd31) ? 31'd0 : (g_ff >> ip_ff[4:0]);
      rnd     = prod_ff + (64'd1 << 25);
      pr      = rnd[63:26];
      big     = (pr >> (SB - 1)) != '0;
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_LOG_MUL: begin
            mul_a = 32'(m_ff);
            mul_b = 32'(m_ff);
         end
         OP_DB_MUL: begin
            mul_a = 32'(lneg);
            mul_b = DB_PER_OCTAVE;
         end
         OP_TGT_MUL: begin
            mul_a = over_gt ? 32'(over) : 32'd0;
            mul_b = 32'(cfg.slope_factor);
         end
         OP_SM_MUL: begin
            mul_a = 32'(absd);
            mul_b = diff_neg ? 32'(cfg.attack_weight) : 32'(cfg.release_weight);
         end
         OP_OCT_MUL: begin
            mul_a = 32'(redmag);
            mul_b = OCTAVE_PER_DB;
         end
         OP_POW_MUL: begin
            mul_a = 32'(g_ff);
            mul_b = 32'(roots[iter]);
         end
         OP_MK_MUL: begin
            mul_a = 32'(gsh);
            mul_b = 32'(cfg.makeup_gain);
         end
         OP_OUT_MUL: begin
            mul_a = 32'(mag_ff);
            mul_b = 32'(gq_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff <= '0;
      end else if (cmd.op == OP_SM_UPD) begin
         red_ff <= diff_neg ? (red_ff - $signed(stepm)) : (red_ff + $signed(stepm));
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            x_neg_ff <= req_sample_in[SB-1];
            mag_ff   <= in_mag;
            m_ff     <= 31'(in_mag);
            s_ff     <= '0;
            frac_ff  <= '0;
            lvl_ff   <= -17'sd32768;
         end
         OP_NORM: begin
            if (!m_ff[30] && m_ff != '0) begin
               if (m_ff[30:23] == '0) begin
                  m_ff <= m_ff << 8;
                  s_ff <= s_ff + 5'd8;
               end else begin
                  m_ff <= m_ff << 1;
                  s_ff <= s_ff + 5'd1;
               end
            end
         end
         OP_LOG_UPD: begin
            if (sq[31]) begin
               m_ff    <= sq[31:1];
               frac_ff <= {frac_ff[T-2:0], 1'b1};
            end else begin
               m_ff    <= sq[30:0];
               frac_ff <= {frac_ff[T-2:0], 1'b0};
            end
         end
         OP_DB_UPD: begin
            if (db_w > 24'd32768) lvl_ff <= -17'sd32768;
            else                  lvl_ff <= -$signed({1'b0, db_w[15:0]});
         end
         OP_TGT_UPD: begin
            tgt_ff <= over_gt ? -$signed({1'b0, prod_ff[9 +: 24]}) : 25'sd0;
         end
         OP_OCT_UPD: begin
            g_ff <= ONE_Q30;
            if (fr != '0) begin
               ip_ff <= ip_n + 8'd1;
               pw_ff <= T'(0) - fr;
            end else begin
               ip_ff <= ip_n;
               pw_ff <= '0;
            end
         end
         OP_POW_UPD: begin
            if (pw_ff[T-1]) g_ff <= prod_ff[60:30];
            pw_ff <= pw_ff << 1;
         end
         OP_MK_UPD: gq_ff <= prod_ff[16 +: 31];
         OP_OUT_UPD: begin
            if (x_neg_ff) y_ff <= big ? {1'b1, {(SB-1){1'b0}}} : SB'(-pr[SB-1:0]);
            else          y_ff <= big ? {1'b0, {(SB-1){1'b1}}} : pr[SB-1:0];
         end
         default: ;
      endcase
   end

   assign sts.mag_zero  = (mag_ff == '0);
   assign sts.norm_done = m_ff[30];
   assign y             = y_ff;

   a_red_not_positive: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SM_UPD) |=> (red_ff <= 24'sd0))
      else $error("reduction went above 0 dB");

endmodule

`default_nettype wire

/* rtl/core/audio_dynamic_range_compressor_core.sv */
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor_core
// Feedforward peak compressor with attack/release smoothing, one sample a beat.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  request | req_valid / req_ready / req_sample_in   | in
//  result  | rsp_valid / rsp_ready / rsp_sample_out  | out
//  config  | csr_write_en / csr_index / csr_wdata    | in
//
//  How long a sample occupies the core is set by the single shared multiplier:
//  each multiply takes a multiply step and an update step over the log and exp
//  loops, plus the steps in the normalize shifter. A zero sample skips the log
//  loop.
//  Reset (synchronous) restores the register defaults and zeroes the reduction.
//  A new beat is taken while a finished result waits in the output register;
//  the sequencer holds in its last step only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_dynamic_range_compressor_core import adrc_pkg::*; #(
   parameter int SAMPLE_BITS     = 16,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   input  wire logic                          csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int IW = $clog2(TABLE_ADDR_BITS);

   adrc_cfg_type           cfg_ff;
   adrc_cmd_type           cmd;
   adrc_sts_type           sts;
   logic [IW-1:0]          iter;
   logic [SAMPLE_BITS-1:0] y;
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_data_ff;
   logic                   out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_level <= RST_THRESHOLD;
         cfg_ff.slope_factor    <= RST_SLOPE;
         cfg_ff.attack_weight   <= RST_ATTACK;
         cfg_ff.release_weight  <= RST_RELEASE;
         cfg_ff.makeup_gain     <= RST_MAKEUP;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: cfg_ff.threshold_level <= csr_wdata;
            CSR_SLOPE:     cfg_ff.slope_factor    <= csr_wdata;
            CSR_ATTACK:    cfg_ff.attack_weight   <= csr_wdata;
            CSR_RELEASE:   cfg_ff.release_weight  <= csr_wdata;
            CSR_MAKEUP:    cfg_ff.makeup_gain     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) rsp_data_ff <= y;
   end

   adrc_ctrl #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .IW              (IW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .out_free  (out_free),
      .cmd       (cmd),
      .iter      (iter)
   );

   adrc_dp #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .IW              (IW)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .iter          (iter),
      .cfg           (cfg_ff),
      .req_sample_in (req_sample_in),
      .sts           (sts),
      .y             (y)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

`default_nettype wire
